>>> design/assert_macros.svh
// assertion macros for the deque rtl
// no dependencies; the asserting module must have clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

>>> design/ladq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the linear array deque
// no dependencies

package ladq_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned FUNC_W    = 3;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned STATUS_W  = 3;

	// operation codes on the input beat
	localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_REAR  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_POP_REAR   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_READOUT    = 3'd4;

	// status codes on the output beat
	localparam logic [STATUS_W-1:0] STAT_DONE       = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_FRONT_FULL = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_REAR_FULL  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY      = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_ELEMENT    = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_READ
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_PUSH_FRONT,
		OP_PUSH_REAR,
		OP_POP_EMPTY,
		OP_POP_START_FRONT,
		OP_POP_START_REAR,
		OP_POP_FINISH,
		OP_READ_START,
		OP_READ_EMIT
	} op_t;

	// controller to datapath
	typedef struct packed {
		op_t op;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic slot_free;
		logic read_last;
	} stat_t;

endpackage

>>> design/ladq_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine for the linear array deque
// depends on ladq_pkg

module ladq_ctrl
	import ladq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	input  stat_t             stat,
	output cmd_t              cmd
);

	state_t state_q, state_d;
	logic   take;

	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && !stat.empty) begin
					if (func == FUNC_POP_FRONT || func == FUNC_POP_REAR) begin
						state_d = ST_POP;
					end else if (func == FUNC_READOUT) begin
						state_d = ST_READ;
					end
				end
			end
			ST_POP: begin
				if (stat.slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (stat.slot_free && stat.read_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = stat.slot_free;
				if (take) begin
					unique case (func)
						FUNC_PUSH_FRONT: cmd.op = OP_PUSH_FRONT;
						FUNC_PUSH_REAR:  cmd.op = OP_PUSH_REAR;
						FUNC_POP_FRONT:  cmd.op = stat.empty ? OP_POP_EMPTY : OP_POP_START_FRONT;
						FUNC_POP_REAR:   cmd.op = stat.empty ? OP_POP_EMPTY : OP_POP_START_REAR;
						FUNC_READOUT:    cmd.op = stat.empty ? OP_NONE : OP_READ_START;
						default:         cmd.op = OP_NONE;
					endcase
				end
			end
			ST_POP: begin
				if (stat.slot_free) begin
					cmd.op = OP_POP_FINISH;
				end
			end
			ST_READ: begin
				if (stat.slot_free) begin
					cmd.op = OP_READ_EMIT;
				end
			end
			default: begin
				cmd.op = OP_NONE;
			end
		endcase
	end

endmodule

>>> design/ladq_dp.sv
`timescale 1ns / 1ps
// storage, indices and output register of the linear array deque
// depends on ladq_pkg and assert_macros.svh

`include "assert_macros.svh"

module ladq_dp
	import ladq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [DATA_W-1:0]   value,
	output stat_t               stat,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] out_status,
	output logic [DATA_W-1:0]   out_data,
	output logic                out_last
);

	localparam int unsigned     AW       = $clog2(DEPTH);
	localparam logic [AW-1:0]   LAST_IDX = AW'(DEPTH - 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	logic [AW-1:0] head_q, tail_q, ptr_q;
	logic          empty_q, side_q;
	logic [AW-1:0] head_d, tail_d, ptr_d;
	logic          empty_d, side_d;

	logic              we, re;
	logic [AW-1:0]     waddr, raddr;

	logic                out_valid_q, out_last_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [DATA_W-1:0]   out_data_q;
	logic                load, ld_last;
	logic [STATUS_W-1:0] ld_status;
	logic [DATA_W-1:0]   ld_data;

	logic slot_free, read_last;

	assign slot_free = !out_valid_q || out_ready;
	assign read_last = (ptr_q == tail_q);

	assign stat.empty     = empty_q;
	assign stat.slot_free = slot_free;
	assign stat.read_last = read_last;

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		ptr_d     = ptr_q;
		empty_d   = empty_q;
		side_d    = side_q;
		we        = 1'b0;
		waddr     = '0;
		re        = 1'b0;
		raddr     = head_q;
		load      = 1'b0;
		ld_status = STAT_DONE;
		ld_data   = '0;
		ld_last   = 1'b1;
		unique case (cmd.op)
			OP_PUSH_FRONT: begin
				load = 1'b1;
				if (empty_q) begin
					we      = 1'b1;
					waddr   = '0;
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b0;
				end else if (head_q == '0) begin
					ld_status = STAT_FRONT_FULL;
				end else begin
					we     = 1'b1;
					waddr  = head_q - AW'(1);
					head_d = head_q - AW'(1);
				end
			end
			OP_PUSH_REAR: begin
				load = 1'b1;
				if (empty_q) begin
					we      = 1'b1;
					waddr   = '0;
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b0;
				end else if (tail_q == LAST_IDX) begin
					ld_status = STAT_REAR_FULL;
				end else begin
					we     = 1'b1;
					waddr  = tail_q + AW'(1);
					tail_d = tail_q + AW'(1);
				end
			end
			OP_POP_EMPTY: begin
				load      = 1'b1;
				ld_status = STAT_EMPTY;
			end
			OP_POP_START_FRONT: begin
				re     = 1'b1;
				raddr  = head_q;
				side_d = 1'b0;
			end
			OP_POP_START_REAR: begin
				re     = 1'b1;
				raddr  = tail_q;
				side_d = 1'b1;
			end
			OP_POP_FINISH: begin
				load    = 1'b1;
				ld_data = rdata_q;
				if (head_q == tail_q) begin
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b1;
				end else if (side_q) begin
					tail_d = tail_q - AW'(1);
				end else begin
					head_d = head_q + AW'(1);
				end
			end
			OP_READ_START: begin
				re    = 1'b1;
				raddr = head_q;
				ptr_d = head_q;
			end
			OP_READ_EMIT: begin
				load      = 1'b1;
				ld_status = STAT_ELEMENT;
				ld_data   = rdata_q;
				ld_last   = read_last;
				// prefetch the next element while this one goes out
				if (!read_last) begin
					re    = 1'b1;
					raddr = ptr_q + AW'(1);
					ptr_d = ptr_q + AW'(1);
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// single port store, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= value;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			ptr_q       <= '0;
			empty_q     <= 1'b1;
			side_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			ptr_q   <= ptr_d;
			empty_q <= empty_d;
			side_q  <= side_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= ld_status;
			out_data_q   <= ld_data;
			out_last_q   <= ld_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_data   = out_data_q;
	assign out_last   = out_last_q;

	`ASSERT_IMPLY(a_empty_at_zero, empty_q, (head_q == '0) && (tail_q == '0), "empty deque with moved indices")
	`ASSERT_ALWAYS(a_index_order, empty_q || (head_q <= tail_q), "head index passed tail index")
	`ASSERT_IMPLY(a_load_needs_slot, load, slot_free, "result loaded over an unsent beat")
	`ASSERT_IMPLY(a_read_in_range, cmd.op == OP_READ_EMIT, !empty_q && (ptr_q >= head_q) && (ptr_q <= tail_q), "read-out pointer outside the stored run")

endmodule

>>> design/linear_array_deque.sv
`timescale 1ns / 1ps
// top level of the linear array double-ended queue
// depends on ladq_pkg, ladq_ctrl and ladq_dp
//
// usage
//   s_axis: one beat per operation; tuser carries the operation code, tdata the value
//   to push (ignored by pops and read-out). m_axis: result beats; tuser carries the
//   status, tdata the popped or read-out value (zero otherwise), tlast marks the final
//   result of an operation.
//   push: result beat registered in the cycle after the input beat. pop: the store is
//   read into a register, then the result beat is loaded once the output is free.
//   read-out: one element per cycle while m_axis_tready is high, after a first store
//   read, tlast on the tail element; an empty deque gives no beats. codes five to
//   seven are dropped. throughput is set by the single store port: one push per cycle
//   while m_axis_tready is high; a pop or read-out holds off the next operation.
//   s_axis_tready is low while a pop or read-out is in flight, and while the output
//   register holds a beat that m_axis_tready does not take; a stalled receiver simply
//   freezes the block with nothing lost.
//   reset empties the deque at once (no clearing pass); store contents stay unknown
//   until written, and are never read before that.

module linear_array_deque
	import ladq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [DATA_W-1:0]   s_axis_tdata,  // [31:0] value
	input  logic [FUNC_W-1:0]   s_axis_tuser,  // [2:0] func
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [DATA_W-1:0]   m_axis_tdata,  // [31:0] data
	output logic [STATUS_W-1:0] m_axis_tuser,  // [2:0] status
	output logic                m_axis_tlast
);

	cmd_t  cmd;
	stat_t stat;

	// controller decodes the operation and steps through pop and read-out
	ladq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.func     (s_axis_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	// store, head/tail indices and the output beat register
	ladq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (s_axis_tdata),
		.stat       (stat),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_data   (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

endmodule
